// File: rtl/core/fde_pkg.sv
// Shared types, constants and helpers for the directory entry scanner.
package fde_pkg;

    localparam int unsigned C_NAME_LEN = 11;
    localparam int unsigned C_BASE_LEN = 8;
    localparam int unsigned C_EXT_LEN  = 3;

    localparam logic [7:0]  C_END_MARK     = 8'h00;
    localparam logic [7:0]  C_DELETED_MARK = 8'hE5;
    localparam logic [7:0]  C_ATTR_LFN     = 8'h0F;
    localparam int unsigned C_ATTR_VOL_BIT = 3;
    localparam int unsigned C_ATTR_DIR_BIT = 4;
    localparam logic [7:0]  C_SPACE        = 8'h20;
    localparam logic [7:0]  C_DOT          = 8'h2E;
    localparam logic [7:0]  C_UPPER_A      = 8'h41;
    localparam logic [7:0]  C_UPPER_Z      = 8'h5A;
    localparam logic [7:0]  C_CASE_OFFSET  = 8'h20;
    localparam logic [4:0]  C_POS_LAST     = 5'd31;

    localparam logic [15:0] C_LIMIT_RESET     = 16'hFFFF;
    localparam logic [31:0] C_MAX_RECORDS_DEF = 32'd65535;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       begin_req;
    } t_in;

    typedef struct packed {
        logic [7:0]  name_char;
        logic        char_valid;
        logic        last_char;
        logic [31:0] start_cluster;
        logic [31:0] byte_length;
        logic        is_folder;
        logic [15:0] record_index;
    } t_out;

    // Snapshot of one finished entry handed to the name serializer
    typedef struct packed {
        logic [C_NAME_LEN-1:0][7:0] name;
        logic                       is_folder;
        logic [31:0]                start_cluster;
        logic [31:0]                byte_length;
        logic [15:0]                record_index;
    } t_entry;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= C_UPPER_A && c <= C_UPPER_Z) begin
            r = c + C_CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/fde_collect.sv
// Byte capture: position counter, entry fields, record count and end-of-entry decision.
module fde_collect #(
    parameter logic [31:0] P_MAX_RECORDS = fde_pkg::C_MAX_RECORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  fde_pkg::t_in        i_in,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    output logic                o_at_last,
    output logic                o_load,
    output fde_pkg::t_entry     o_entry
);
    import fde_pkg::*;

    logic [4:0]                  r_pos, n_pos;
    logic [C_NAME_LEN-1:0][7:0]  r_name, n_name;
    logic [7:0]                  r_attr, n_attr;
    logic [15:0]                 r_clu_hi, n_clu_hi;
    logic [15:0]                 r_clu_lo, n_clu_lo;
    logic [31:0]                 r_size, n_size;
    logic [15:0]                 r_found, n_found;
    logic                        r_stopped, n_stopped;
    logic [15:0]                 r_limit;

    logic [4:0]  eff_pos;
    logic [15:0] eff_found;
    logic        eff_stopped;
    logic        limit_hit;
    logic        load;

    // Resolve a begin beat before the byte is taken
    always_comb begin
        eff_pos     = i_in.begin_req ? 5'd0  : r_pos;
        eff_found   = i_in.begin_req ? 16'd0 : r_found;
        eff_stopped = i_in.begin_req ? 1'b0  : r_stopped;
        limit_hit   = (eff_found >= r_limit) || ({16'd0, eff_found} >= P_MAX_RECORDS);
    end

    // Store the byte, advance the position, decide at the entry's last byte
    always_comb begin
        n_pos     = r_pos;
        n_name    = r_name;
        n_attr    = r_attr;
        n_clu_hi  = r_clu_hi;
        n_clu_lo  = r_clu_lo;
        n_size    = r_size;
        n_found   = r_found;
        n_stopped = r_stopped;
        load      = 1'b0;
        if (i_accept) begin
            n_pos     = eff_pos;
            n_found   = eff_found;
            n_stopped = eff_stopped;
            if (!eff_stopped) begin
                case (eff_pos) inside
                    [5'd0:5'd10]:  n_name[eff_pos[3:0]] = i_in.data_byte;
                    5'd11:         n_attr = i_in.data_byte;
                    5'd20:         n_clu_hi[7:0]  = i_in.data_byte;
                    5'd21:         n_clu_hi[15:8] = i_in.data_byte;
                    5'd26:         n_clu_lo[7:0]  = i_in.data_byte;
                    5'd27:         n_clu_lo[15:8] = i_in.data_byte;
                    [5'd28:5'd31]: n_size[eff_pos[1:0]*8 +: 8] = i_in.data_byte;
                    default:       ;
                endcase
                n_pos = eff_pos + 5'd1;
                if (eff_pos == C_POS_LAST && !limit_hit) begin
                    if (r_name[0] == C_END_MARK) begin
                        n_stopped = 1'b1;
                    end else if (r_name[0] != C_DELETED_MARK && r_attr != C_ATTR_LFN &&
                                 !r_attr[C_ATTR_VOL_BIT]) begin
                        load    = 1'b1;
                        n_found = eff_found + 16'd1;
                    end
                end
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_found   <= '0;
            r_stopped <= 1'b0;
            r_limit   <= C_LIMIT_RESET;
        end else begin
            r_pos     <= n_pos;
            r_found   <= n_found;
            r_stopped <= n_stopped;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Entry fields carry no reset
    always_ff @(posedge i_clk) begin
        r_name   <= n_name;
        r_attr   <= n_attr;
        r_clu_hi <= n_clu_hi;
        r_clu_lo <= n_clu_lo;
        r_size   <= n_size;
    end

    assign o_at_last = (r_pos == C_POS_LAST);
    assign o_load    = load;
    always_comb begin
        o_entry.name          = r_name;
        o_entry.is_folder     = r_attr[C_ATTR_DIR_BIT];
        o_entry.start_cluster = {r_clu_hi, r_clu_lo};
        o_entry.byte_length   = n_size;
        o_entry.record_index  = eff_found;
    end

    a_load_at_entry_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_pos == C_POS_LAST) && !i_in.begin_req)
        else $error("record emitted away from the entry's last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_found == $past(eff_found) + 16'd1)
        else $error("record count did not advance on an emitted record");

    a_stop_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && !i_in.begin_req) |=> r_pos == $past(r_pos))
        else $error("byte position moved while the scan was stopped");

endmodule

// File: rtl/core/fde_emit.sv
// Name serializer: trims and lower-cases the 8.3 name and sends one character per beat.
module fde_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  fde_pkg::t_entry  i_entry,
    output logic             o_busy,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output fde_pkg::t_out    o_out_data
);
    import fde_pkg::*;

    logic           r_busy, n_busy;
    logic [3:0]     r_k, n_k;
    t_entry         r_ent;
    logic           r_oval, n_oval;
    t_out           r_out, n_out;

    logic [3:0] base_end;
    logic [3:0] ext_end;
    logic [3:0] total;
    logic [3:0] last_k;
    logic [3:0] ext_idx;
    logic       step;

    // Find the trimmed base and extension lengths
    always_comb begin
        base_end = '0;
        ext_end  = '0;
        for (int i = 0; i < C_BASE_LEN; i++) begin
            if (r_ent.name[i] != C_SPACE) begin
                base_end = 4'(i + 1);
            end
        end
        for (int j = 0; j < C_EXT_LEN; j++) begin
            if (r_ent.name[C_BASE_LEN + j] != C_SPACE) begin
                ext_end = 4'(j + 1);
            end
        end
        total   = base_end + ((ext_end != 4'd0) ? (ext_end + 4'd1) : 4'd0);
        last_k  = (total == 4'd0) ? 4'd0 : (total - 4'd1);
        ext_idx = r_k - base_end + 4'd7;
    end

    // Advance one character whenever the output register is free
    always_comb begin
        step   = r_busy && (!r_oval || i_out_ready);
        n_busy = r_busy;
        n_k    = r_k;
        n_oval = r_oval && !i_out_ready;
        n_out  = r_out;
        if (i_load) begin
            n_busy = 1'b1;
            n_k    = 4'd0;
        end else if (step) begin
            n_oval              = 1'b1;
            n_out.char_valid    = (total != 4'd0);
            n_out.last_char     = (r_k == last_k);
            n_out.start_cluster = r_ent.start_cluster;
            n_out.byte_length   = r_ent.byte_length;
            n_out.is_folder     = r_ent.is_folder;
            n_out.record_index  = r_ent.record_index;
            if (total == 4'd0) begin
                n_out.name_char = 8'h00;
            end else if (r_k < base_end) begin
                n_out.name_char = lower_ascii(r_ent.name[r_k]);
            end else if (r_k == base_end) begin
                n_out.name_char = C_DOT;
            end else begin
                n_out.name_char = lower_ascii(r_ent.name[ext_idx]);
            end
            if (r_k == last_k) begin
                n_busy = 1'b0;
            end else begin
                n_k = r_k + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_oval <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_k    <= n_k;
            r_oval <= n_oval;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_load) begin
            r_ent <= i_entry;
        end
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy)
        else $error("new record loaded over one still being sent");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_k <= last_k)
        else $error("character index ran past the name length");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_k == last_k) |=> r_oval && r_out.last_char)
        else $error("final character of a record not marked last");

endmodule

// File: rtl/core/fat_directory_entry_scanner.sv
// Top level of the FAT directory entry scanner: byte capture feeding a name serializer.
//
//  channel | valid / ready            | payload
//  --------+--------------------------+--------------------------
//  in      | i_in_valid / o_in_ready  | i_in_data  (t_in, one directory byte)
//  out     | o_out_valid / i_out_ready| o_out_data (t_out, one name character)
//  cfg     | i_cfg_valid / o_cfg_ready| i_cfg_data (entry_limit)
//
// One input byte per cycle while o_in_ready is high. A record's name leaves as 1 to 12
// beats, one per cycle while ready; the first beat is registered after the entry loads.
// The last byte of an entry waits while the previous record's name is still being sent.
// Reset is synchronous; entry_limit returns to 65535, count and stop state clear.
// A stalled output holds its beat while input bytes keep flowing into the next entry.
module fat_directory_entry_scanner #(
    parameter logic [31:0] P_MAX_RECORDS = fde_pkg::C_MAX_RECORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fde_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fde_pkg::t_out  o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import fde_pkg::*;

    logic   at_last;
    logic   busy;
    logic   load;
    logic   in_accept;
    t_entry entry;

    // Hold the entry's last byte while a name is still in flight
    assign o_in_ready  = !(at_last && busy);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    fde_collect #(
        .P_MAX_RECORDS (P_MAX_RECORDS)
    ) u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_in       (i_in_data),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_at_last  (at_last),
        .o_load     (load),
        .o_entry    (entry)
    );

    fde_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_entry     (entry),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: test/fat_directory_entry_scanner_tb.sv
// Self-checking testbench for the FAT directory entry scanner.
module fat_directory_entry_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fde_pkg::*;

    typedef logic [C_NAME_LEN-1:0][7:0] name_t;

    // Byte offsets inside one 32-byte directory entry
    localparam int unsigned ENTRY_BYTES = 32;
    localparam int unsigned OFS_ATTR    = 11;
    localparam int unsigned OFS_CLUS_HI = 20;
    localparam int unsigned OFS_CLUS_LO = 26;
    localparam int unsigned OFS_SIZE    = 28;

    localparam logic [7:0] LEAD_05      = 8'h05;
    localparam logic [7:0] ATTR_ARCHIVE = 8'h20;
    localparam logic [7:0] ATTR_DIR     = 8'(1 << C_ATTR_DIR_BIT);
    localparam logic [7:0] ATTR_VOLUME  = 8'(1 << C_ATTR_VOL_BIT);

    localparam int unsigned RUN_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYC  = 20;
    localparam int unsigned HOLD_CYC    = 300;
    localparam int unsigned MAX_REPORTS = 10;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    t_in           i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    t_out          o_out_data;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [15:0]   i_cfg_data = '0;

    // Stimulus and expectation stores
    t_in           dir_bytes [$];
    t_out          due_chars [$];
    int unsigned   bytes_pushed = 0;
    bit            next_begin = 1'b0;

    // Traffic shaping, changed only on the falling edge
    int unsigned   tx_idle_pct = 0;
    int unsigned   rx_stall_pct = 0;
    bit            hold_req = 1'b0;

    // Long receiver hold, counted by its own process
    bit            hold_done = 1'b0;
    int unsigned   hold_cnt = 0;
    logic          rx_hold;

    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;

    // Scanner state as the testbench sees it
    logic [4:0]    entry_pos = '0;
    logic [7:0]    held_name [C_NAME_LEN];
    logic [7:0]    held_attr;
    logic [15:0]   clus_hi_w;
    logic [15:0]   clus_lo_w;
    logic [31:0]   file_len;
    logic [15:0]   rec_count = '0;
    bit            halted = 1'b0;
    logic [15:0]   limit_reg = C_LIMIT_RESET;

    fat_directory_entry_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Set bit 5 on upper-case letters only
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= C_UPPER_A && c <= C_UPPER_Z) begin
            return {c[7:6], 1'b1, c[4:0]};
        end
        return c;
    endfunction

    // Advance the scanner state by one accepted byte, queue the name beats it causes
    function automatic void decode_dir_byte(input t_in beat);
        logic [4:0]  p;
        int          base_len;
        int          ext_len;
        logic [7:0]  chars [$];
        t_out        rec;
        if (beat.begin_req) begin
            rec_count = '0;
            halted    = 1'b0;
            entry_pos = '0;
        end
        if (halted) begin
            return;
        end
        p = entry_pos;
        if (p < C_NAME_LEN) begin
            held_name[p] = beat.data_byte;
        end else if (p == OFS_ATTR) begin
            held_attr = beat.data_byte;
        end else if (p == OFS_CLUS_HI) begin
            clus_hi_w[7:0] = beat.data_byte;
        end else if (p == OFS_CLUS_HI + 1) begin
            clus_hi_w[15:8] = beat.data_byte;
        end else if (p == OFS_CLUS_LO) begin
            clus_lo_w[7:0] = beat.data_byte;
        end else if (p == OFS_CLUS_LO + 1) begin
            clus_lo_w[15:8] = beat.data_byte;
        end else if (p >= OFS_SIZE) begin
            file_len[8 * (p - OFS_SIZE) +: 8] = beat.data_byte;
        end
        entry_pos = p + 5'd1;
        if (p != C_POS_LAST) begin
            return;
        end

        // Entry complete: limit first, then end mark, deleted, long name and label
        if (rec_count >= limit_reg || {16'h0, rec_count} >= C_MAX_RECORDS_DEF) begin
            return;
        end
        if (held_name[0] == C_END_MARK) begin
            halted = 1'b1;
            return;
        end
        if (held_name[0] == C_DELETED_MARK) begin
            return;
        end
        if (held_attr == C_ATTR_LFN || held_attr[C_ATTR_VOL_BIT]) begin
            return;
        end

        // Trim trailing blanks, fold case, add the dot only before an extension
        base_len = C_BASE_LEN;
        while (base_len > 0 && held_name[base_len - 1] == C_SPACE) begin
            base_len--;
        end
        ext_len = C_EXT_LEN;
        while (ext_len > 0 && held_name[C_BASE_LEN + ext_len - 1] == C_SPACE) begin
            ext_len--;
        end
        for (int i = 0; i < base_len; i++) begin
            chars.push_back(fold_case(held_name[i]));
        end
        if (ext_len > 0) begin
            chars.push_back(C_DOT);
            for (int i = 0; i < ext_len; i++) begin
                chars.push_back(fold_case(held_name[C_BASE_LEN + i]));
            end
        end

        rec.start_cluster = {clus_hi_w, clus_lo_w};
        rec.byte_length   = file_len;
        rec.is_folder     = held_attr[C_ATTR_DIR_BIT];
        rec.record_index  = rec_count;
        if (chars.size() == 0) begin
            rec.name_char  = '0;
            rec.char_valid = 1'b0;
            rec.last_char  = 1'b1;
            due_chars.push_back(rec);
        end
        for (int i = 0; i < chars.size(); i++) begin
            rec.name_char  = chars[i];
            rec.char_valid = 1'b1;
            rec.last_char  = (i == chars.size() - 1);
            due_chars.push_back(rec);
        end
        rec_count++;
    endfunction

    function automatic name_t short_name_of(input string s);
        name_t nm;
        for (int i = 0; i < C_NAME_LEN; i++) begin
            nm[i] = (i < s.len()) ? s[i] : C_SPACE;
        end
        return nm;
    endfunction

    function automatic void push_dir_byte(input logic [7:0] b, input logic beg);
        dir_bytes.push_back(t_in'{data_byte: b, begin_req: beg});
        bytes_pushed++;
    endfunction

    // Lay out one entry and queue its first n_bytes bytes
    function automatic void push_entry(input name_t nm, input logic [7:0] attr,
                                       input logic [31:0] clus, input logic [31:0] len,
                                       input bit beg, input int n_bytes = ENTRY_BYTES);
        logic [7:0] ent [ENTRY_BYTES];
        for (int i = 0; i < ENTRY_BYTES; i++) begin
            ent[i] = 8'($urandom);
        end
        for (int i = 0; i < C_NAME_LEN; i++) begin
            ent[i] = nm[i];
        end
        ent[OFS_ATTR]        = attr;
        ent[OFS_CLUS_HI]     = clus[23:16];
        ent[OFS_CLUS_HI + 1] = clus[31:24];
        ent[OFS_CLUS_LO]     = clus[7:0];
        ent[OFS_CLUS_LO + 1] = clus[15:8];
        for (int i = 0; i < 4; i++) begin
            ent[OFS_SIZE + i] = len[8 * i +: 8];
        end
        for (int i = 0; i < n_bytes; i++) begin
            push_dir_byte(ent[i], (i == 0) ? beg : 1'b0);
        end
    endfunction

    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return C_UPPER_A + 8'($urandom_range(0, 25));
            4:          return 8'h30 + 8'($urandom_range(0, 9));
            5:          return C_UPPER_A + C_CASE_OFFSET + 8'($urandom_range(0, 25));
            6:          return C_UPPER_A - 8'd1;
            7:          return C_UPPER_Z + 8'd1;
            default:    return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed entries with random content, some noise and broken entries
    function automatic void push_random_entry();
        name_t      nm;
        logic [7:0] attr;
        int         base_n;
        int         ext_n;
        int         roll;
        int         n_bytes;
        bit         beg;
        beg = next_begin || ($urandom_range(0, 19) == 0);
        next_begin = 1'b0;
        if ($urandom_range(0, 99) < 4) begin
            for (int i = 0; i < ENTRY_BYTES; i++) begin
                push_dir_byte(8'($urandom), ($urandom_range(0, 15) == 0) || (i == 0 && beg));
            end
            return;
        end

        base_n = $urandom_range(0, C_BASE_LEN);
        ext_n  = $urandom_range(0, C_EXT_LEN);
        for (int i = 0; i < C_BASE_LEN; i++) begin
            nm[i] = (i < base_n) ? pick_name_char() : C_SPACE;
        end
        for (int i = 0; i < C_EXT_LEN; i++) begin
            nm[C_BASE_LEN + i] = (i < ext_n) ? pick_name_char() : C_SPACE;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            nm[0] = C_END_MARK;
            next_begin = ($urandom_range(0, 4) != 0);
        end else if (roll < 12) begin
            nm[0] = C_DELETED_MARK;
        end else if (roll < 15) begin
            nm[0] = LEAD_05;
        end

        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            attr = C_ATTR_LFN;
        end else if (roll < 14) begin
            attr = 8'($urandom) | ATTR_VOLUME;
        end else if (roll < 40) begin
            attr = ATTR_DIR;
        end else if (roll < 60) begin
            attr = ATTR_ARCHIVE;
        end else begin
            attr = 8'($urandom) & ~ATTR_VOLUME;
        end

        // Cut a few entries short and restart the scan on the next one
        n_bytes = ENTRY_BYTES;
        if ($urandom_range(0, 99) < 5) begin
            n_bytes = $urandom_range(1, ENTRY_BYTES - 1);
            next_begin = 1'b1;
        end
        push_entry(nm, attr, $urandom, $urandom, beg, n_bytes);
    endfunction

    function automatic void push_random_run(input int unsigned n_bytes);
        int unsigned start;
        start = bytes_pushed;
        next_begin = 1'b1;
        while (bytes_pushed - start < n_bytes) begin
            push_random_entry();
        end
    endfunction

    // Wait until the block has nothing left to do, then let it settle
    task automatic drain_scanner();
        while (dir_bytes.size() != 0 || i_in_valid || due_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_entry_limit(input logic [15:0] lim);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        limit_reg = lim;
        @(negedge i_clk);
    endtask

    // Count the long receiver hold once it is requested
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            if (hold_cnt == HOLD_CYC - 1) begin
                hold_done <= 1'b1;
            end
            hold_cnt <= hold_cnt + 1;
        end
    end

    assign rx_hold = hold_req && !hold_done;

    // Driver: offer queued bytes, update the prediction on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_dir_byte(i_in_data);
            end
            if (!i_in_valid || o_in_ready) begin
                if (dir_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= dir_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted name beat against the oldest expectation
    always @(posedge i_clk) begin
        t_out exp_beat;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (due_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected name beat: char %h valid %0b last %0b idx %0d",
                                 o_out_data.name_char, o_out_data.char_valid,
                                 o_out_data.last_char, o_out_data.record_index);
                    end
                end else begin
                    exp_beat = due_chars.pop_front();
                    if (o_out_data.name_char     !== exp_beat.name_char     ||
                        o_out_data.char_valid    !== exp_beat.char_valid    ||
                        o_out_data.last_char     !== exp_beat.last_char     ||
                        o_out_data.start_cluster !== exp_beat.start_cluster ||
                        o_out_data.byte_length   !== exp_beat.byte_length   ||
                        o_out_data.is_folder     !== exp_beat.is_folder     ||
                        o_out_data.record_index  !== exp_beat.record_index) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch expected: ch %h v %0b l %0b cl %h len %h d %0b ix %0d",
                                     exp_beat.name_char, exp_beat.char_valid,
                                     exp_beat.last_char, exp_beat.start_cluster,
                                     exp_beat.byte_length, exp_beat.is_folder,
                                     exp_beat.record_index);
                            $display("mismatch actual:   ch %h v %0b l %0b cl %h len %h d %0b ix %0d",
                                     o_out_data.name_char, o_out_data.char_valid,
                                     o_out_data.last_char, o_out_data.start_cluster,
                                     o_out_data.byte_length, o_out_data.is_folder,
                                     o_out_data.record_index);
                        end
                    end
                end
            end
            i_out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        name_t nm;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Name forms under the reset limit, no idling
        push_entry(short_name_of(""), ATTR_DIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_entry(short_name_of("        ABC"), 8'h00, 32'h1234_5678, 32'h8000_0001, 1'b0);
        nm = short_name_of("@Z[Az_9@C{ ");
        nm[0] = LEAD_05;
        push_entry(nm, ATTR_ARCHIVE, 32'h00FF_FF00, 32'd1, 1'b0);
        drain_scanner();

        // Skipped entries, mid-entry restart and end mark, sender idles
        tx_idle_pct = 45;
        rx_stall_pct = 0;
        nm = short_name_of("DELETED TXT");
        nm[0] = C_DELETED_MARK;
        push_entry(nm, ATTR_ARCHIVE, 32'd7, 32'd7, 1'b0);
        push_entry(short_name_of("VOLUME"), ATTR_VOLUME, 32'd0, 32'd0, 1'b0);
        // scan restart in the middle of an entry
        push_entry(short_name_of("PARTIAL"), ATTR_ARCHIVE, 32'd0, 32'd0, 1'b0, 10);
        push_entry(short_name_of("AFTERMIDBEG"), ATTR_ARCHIVE, 32'd9, 32'd9, 1'b1);
        // end mark stops the scan until the next begin
        nm = short_name_of("ENDMARK");
        nm[0] = C_END_MARK;
        push_entry(nm, ATTR_ARCHIVE, 32'd0, 32'd0, 1'b0);
        push_entry(short_name_of("IGNORED TXT"), ATTR_ARCHIVE, 32'd1, 32'd1, 1'b0);
        push_entry(short_name_of("SCAN2   BIN"), ATTR_ARCHIVE, 32'd2, 32'd2, 1'b1);
        drain_scanner();

        // Limit of one: once reached, an end mark no longer stops the scan
        write_entry_limit(16'd1);
        tx_idle_pct = 0;
        rx_stall_pct = 45;
        push_entry(short_name_of("ONE     TXT"), ATTR_ARCHIVE, 32'd1, 32'd10, 1'b1);
        nm = short_name_of("ENDMARK");
        nm[0] = C_END_MARK;
        push_entry(nm, ATTR_ARCHIVE, 32'd0, 32'd0, 1'b0);
        drain_scanner();
        // raising the limit lets the same scan report again
        write_entry_limit(16'd2);
        push_entry(short_name_of("TWO     TXT"), ATTR_DIR, 32'd2, 32'd20, 1'b0);
        drain_scanner();

        // Zero limit, random content
        write_entry_limit(16'd0);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        push_random_run(32);
        drain_scanner();

        // Both sides idle; hold the receiver off while bytes keep coming
        write_entry_limit(16'hFFFF);
        tx_idle_pct = 21;
        rx_stall_pct = 21;
        push_entry(short_name_of("LONGNAMETXT"), ATTR_ARCHIVE, 32'h0BAD_F00D, 32'd4096, 1'b1);
        push_entry(short_name_of("SECOND  BIN"), ATTR_DIR, 32'd11, 32'd12, 1'b0);
        hold_req = 1'b1;
        wait (hold_done);
        drain_scanner();

        repeat (SETTLE_CYC + 10) @(posedge i_clk);
        if (mismatches == 0 && due_chars.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
